// ===== sv/vdu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdu_pkg
// Shared constants, types and helpers of the 2x voxel upscaler.
// ----------------------------------------------------------------------------
package vdu_pkg;

  // Default volume limits
  localparam int DefMaxCols   = 64;
  localparam int DefMaxRows   = 64;
  localparam int DefMaxPlanes = 64;

  // Field widths
  localparam int DimW   = 7;
  localparam int CoordW = 7;
  localparam int VoxW   = 16;
  localparam int CoefW  = 16;
  localparam int OutW   = 24;
  localparam int VolW   = 8;

  // Configuration register indexes
  localparam logic [1:0] CFG_COLS   = 2'd0;
  localparam logic [1:0] CFG_ROWS   = 2'd1;
  localparam logic [1:0] CFG_PLANES = 2'd2;

  // Input item modes
  localparam logic MODE_COEF  = 1'b0;
  localparam logic MODE_VOXEL = 1'b1;

  // One result beat
  typedef struct packed {
    logic [CoordW-1:0]      out_x;
    logic [CoordW-1:0]      out_y;
    logic [CoordW-1:0]      out_z;
    logic signed [OutW-1:0] out_value;
    logic                   last;
    logic                   end_of_volume;
    logic [VolW-1:0]        volume_index;
  } out_beat_t;

  // Last valid index of a dimension: zero acts as one, large values saturate
  function automatic int dim_last(logic [DimW-1:0] v, int maxv);
    int r;
    r = int'(v);
    if (r == 0) begin
      return 0;
    end
    if (r > maxv) begin
      return maxv - 1;
    end
    return r - 1;
  endfunction

endpackage

// ===== sv/vdu_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdu_if
// Valid/ready channels of the voxel upscaler: input items and result beats.
// ----------------------------------------------------------------------------
interface vdu_in_if;
  logic                               valid;
  logic                               ready;
  logic                               mode;
  logic [5:0]                         weight_index;
  logic signed [vdu_pkg::CoefW-1:0]   weight_value;
  logic signed [vdu_pkg::VoxW-1:0]    voxel_value;

  modport source (output valid, mode, weight_index, weight_value, voxel_value,
                  input ready);
  modport sink   (input valid, mode, weight_index, weight_value, voxel_value,
                  output ready);
endinterface

interface vdu_out_if;
  logic                              valid;
  logic                              ready;
  logic [vdu_pkg::CoordW-1:0]        out_x;
  logic [vdu_pkg::CoordW-1:0]        out_y;
  logic [vdu_pkg::CoordW-1:0]        out_z;
  logic signed [vdu_pkg::OutW-1:0]   out_value;
  logic                              last;
  logic                              end_of_volume;
  logic [vdu_pkg::VolW-1:0]          volume_index;

  modport source (output valid, out_x, out_y, out_z, out_value, last,
                  end_of_volume, volume_index, input ready);
  modport sink   (input valid, out_x, out_y, out_z, out_value, last,
                  end_of_volume, volume_index, output ready);
endinterface

// ===== sv/voxel_deconv_upscale_2x.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_deconv_upscale_2x
// 3-D stride-2 transposed convolution with a 4x4x4 kernel: every input voxel
// yields its eight output voxels.
//
//   channel   dir  handshake      beat
//   vox_in    in   valid/ready    mode, weight_index, weight_value, voxel_value
//   vox_out   out  valid/ready    coordinates, out_value, last, eov, volume
//   cfg       in   cfg_we_i       cfg_idx_i, cfg_data_i
//
// The seven stored neighbours of a voxel are read one per cycle through the
// single read port of the history memory, while the previous voxel sends its
// eight results, one per cycle while the output does not stall, through
// multiply and adder stages.
// A coefficient beat waits until no voxel is in fetch or multiply.
// Reset clears counters and valid flags; memories are not cleared.
// Output stall holds the whole result pipeline.
// ----------------------------------------------------------------------------
module voxel_deconv_upscale_2x #(
  parameter int MAX_COLS   = vdu_pkg::DefMaxCols,
  parameter int MAX_ROWS   = vdu_pkg::DefMaxRows,
  parameter int MAX_PLANES = vdu_pkg::DefMaxPlanes
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [vdu_pkg::DimW-1:0]   cfg_data_i,
  vdu_in_if.sink                     vox_in,
  vdu_out_if.source                  vox_out
);

  localparam int CW    = $clog2(MAX_COLS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int PW    = $clog2(MAX_PLANES);
  localparam int AW    = 1 + RW + CW;
  localparam int Depth = 2 ** AW;
  localparam int VW    = vdu_pkg::VoxW;
  localparam int PRW   = vdu_pkg::VoxW + vdu_pkg::CoefW;

  // Dimension limits and raster counters
  logic [CW-1:0] clast_q;
  logic [RW-1:0] rlast_q;
  logic [PW-1:0] plast_q;
  logic [CW-1:0] i_q;
  logic [RW-1:0] j_q;
  logic [PW-1:0] k_q;
  logic [vdu_pkg::VolW-1:0] vol_q;
  logic          cfg_known;

  // Fetch stage
  logic          f_busy_q, f_hold_q;
  logic [2:0]    fcnt_q;
  logic [CW-1:0] fi_q;
  logic [RW-1:0] fj_q;
  logic [PW-1:0] fk_q;
  logic [vdu_pkg::VolW-1:0] fvol_q;
  logic          fend_q;
  logic signed [VW-1:0] nb_q [8];
  logic          mvalid_q;

  // Compute stage
  logic          c_busy_q;
  logic [2:0]    ocnt_q;
  logic [CW-1:0] ci_q;
  logic [RW-1:0] cj_q;
  logic [PW-1:0] ck_q;
  logic [vdu_pkg::VolW-1:0] cvol_q;
  logic          cend_q;
  logic signed [VW-1:0] cnb_q [8];

  // Coefficients, banked by neighbour lane
  logic signed [vdu_pkg::CoefW-1:0] coef_q [8][8];

  // History memory
  logic [VW-1:0] hist_mem [Depth];
  logic [VW-1:0] rdata_q;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;

  // Result pipeline
  logic                   p_v_q, a1_v_q, a2_v_q, o_v_q;
  logic signed [PRW-1:0]  prod_q [8];
  logic signed [PRW:0]    s4_q [4];
  logic signed [PRW+1:0]  s2_q [2];
  vdu_pkg::out_beat_t     c_tag, p_tag_q, a1_tag_q, a2_tag_q, o_d, o_q;

  logic acc_vox, acc_coef, adv, f_end, c_take, handoff, m_ok, vol_end;
  logic [2:0] m;
  logic signed [VW-1:0] nb7;
  logic signed [PRW+2:0] acc;
  logic [CW+7:0] xw;
  logic [RW+7:0] yw;
  logic [PW+7:0] zw;

  // Handshake control
  assign adv     = !o_v_q || vox_out.ready;
  assign f_end   = f_busy_q && (fcnt_q == 3'd7);
  assign c_take  = !c_busy_q || ((ocnt_q == 3'd7) && adv);
  assign handoff = f_end && c_take;

  always_comb begin
    if (vox_in.mode == vdu_pkg::MODE_VOXEL) begin
      vox_in.ready = !f_busy_q || handoff;
    end else begin
      vox_in.ready = !f_busy_q && !c_busy_q;
    end
  end

  assign acc_vox  = vox_in.valid && vox_in.ready && (vox_in.mode == vdu_pkg::MODE_VOXEL);
  assign acc_coef = vox_in.valid && vox_in.ready && (vox_in.mode == vdu_pkg::MODE_COEF);
  assign vol_end  = (i_q == clast_q) && (j_q == rlast_q) && (k_q == plast_q);

  assign cfg_known = (cfg_idx_i == vdu_pkg::CFG_COLS) || (cfg_idx_i == vdu_pkg::CFG_ROWS) ||
                     (cfg_idx_i == vdu_pkg::CFG_PLANES);

  // Configuration and raster counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clast_q <= CW'(vdu_pkg::dim_last(7'd64, MAX_COLS));
      rlast_q <= RW'(vdu_pkg::dim_last(7'd64, MAX_ROWS));
      plast_q <= PW'(vdu_pkg::dim_last(7'd64, MAX_PLANES));
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      vol_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        vdu_pkg::CFG_COLS: begin
          clast_q <= CW'(vdu_pkg::dim_last(cfg_data_i, MAX_COLS));
        end
        vdu_pkg::CFG_ROWS: begin
          rlast_q <= RW'(vdu_pkg::dim_last(cfg_data_i, MAX_ROWS));
        end
        vdu_pkg::CFG_PLANES: begin
          plast_q <= PW'(vdu_pkg::dim_last(cfg_data_i, MAX_PLANES));
        end
        default: begin
        end
      endcase
      if (cfg_known) begin
        i_q <= '0;
        j_q <= '0;
        k_q <= '0;
      end
    end else if (acc_vox) begin
      if (i_q != clast_q) begin
        i_q <= i_q + CW'(1);
      end else begin
        i_q <= '0;
        if (j_q != rlast_q) begin
          j_q <= j_q + RW'(1);
        end else begin
          j_q <= '0;
          if (k_q != plast_q) begin
            k_q <= k_q + PW'(1);
          end else begin
            k_q   <= '0;
            vol_q <= vol_q + 8'd1;
          end
        end
      end
    end
  end

  // Coefficient banks: lane from the odd index bits, output from the even
  always_ff @(posedge clk_i) begin
    if (acc_coef) begin
      coef_q[{vox_in.weight_index[5], vox_in.weight_index[3], vox_in.weight_index[1]}]
            [{vox_in.weight_index[4], vox_in.weight_index[2], vox_in.weight_index[0]}]
        <= vox_in.weight_value;
    end
  end

  // Neighbour read address and edge mask for the lane being fetched
  always_comb begin
    m     = fcnt_q + 3'd1;
    m_ok  = !(m[0] && (fi_q == '0)) && !(m[1] && (fj_q == '0)) && !(m[2] && (fk_q == '0));
    raddr = {fk_q[0] ^ m[2], fj_q - RW'(m[1]), fi_q - CW'(m[0])};
    waddr = {k_q[0], j_q, i_q};
  end

  // History memory: write on voxel accept, registered read
  always_ff @(posedge clk_i) begin
    if (acc_vox) begin
      hist_mem[waddr] <= vox_in.voxel_value;
    end
    rdata_q <= hist_mem[raddr];
  end

  // Fetch sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_busy_q <= 1'b0;
      f_hold_q <= 1'b0;
      fcnt_q   <= '0;
      mvalid_q <= 1'b0;
    end else begin
      mvalid_q <= m_ok;
      if (acc_vox) begin
        f_busy_q <= 1'b1;
        f_hold_q <= 1'b0;
        fcnt_q   <= '0;
      end else if (f_busy_q) begin
        if (fcnt_q != 3'd7) begin
          fcnt_q <= fcnt_q + 3'd1;
        end else if (handoff) begin
          f_busy_q <= 1'b0;
        end else begin
          f_hold_q <= 1'b1;
        end
      end
    end
  end

  // Capture fetch payload and neighbours
  always_ff @(posedge clk_i) begin
    if (acc_vox) begin
      fi_q     <= i_q;
      fj_q     <= j_q;
      fk_q     <= k_q;
      fvol_q   <= vol_q;
      fend_q   <= vol_end;
      nb_q[0]  <= vox_in.voxel_value;
    end
    if (f_busy_q && (fcnt_q != 3'd0) && !f_hold_q) begin
      nb_q[fcnt_q] <= mvalid_q ? rdata_q : '0;
    end
  end

  assign nb7 = f_hold_q ? nb_q[7] : (mvalid_q ? rdata_q : '0);

  // Compute stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_busy_q <= 1'b0;
      ocnt_q   <= '0;
    end else if (handoff) begin
      c_busy_q <= 1'b1;
      ocnt_q   <= '0;
    end else if (c_busy_q && adv) begin
      ocnt_q <= ocnt_q + 3'd1;
      if (ocnt_q == 3'd7) begin
        c_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (handoff) begin
      ci_q   <= fi_q;
      cj_q   <= fj_q;
      ck_q   <= fk_q;
      cvol_q <= fvol_q;
      cend_q <= fend_q;
      for (int n = 0; n < 7; n++) begin
        cnb_q[n] <= nb_q[n];
      end
      cnb_q[7] <= nb7;
    end
  end

  // Tag of the result being issued
  always_comb begin
    xw = {7'd0, ci_q, ocnt_q[0]};
    yw = {7'd0, cj_q, ocnt_q[1]};
    zw = {7'd0, ck_q, ocnt_q[2]};
    c_tag               = '0;
    c_tag.out_x         = xw[6:0];
    c_tag.out_y         = yw[6:0];
    c_tag.out_z         = zw[6:0];
    c_tag.last          = (ocnt_q == 3'd7);
    c_tag.end_of_volume = (ocnt_q == 3'd7) && cend_q;
    c_tag.volume_index  = cvol_q;
  end

  // Result pipeline valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q  <= 1'b0;
      a1_v_q <= 1'b0;
      a2_v_q <= 1'b0;
      o_v_q  <= 1'b0;
    end else if (adv) begin
      p_v_q  <= c_busy_q;
      a1_v_q <= p_v_q;
      a2_v_q <= a1_v_q;
      o_v_q  <= a2_v_q;
    end
  end

  assign acc = (PRW+3)'(s2_q[0]) + (PRW+3)'(s2_q[1]) + (PRW+3)'(8192);

  // Round the final sum into the outgoing beat
  always_comb begin
    o_d           = a2_tag_q;
    o_d.out_value = {{3{acc[PRW+2]}}, acc[PRW+2:14]};
  end

  // Multiply, add tree, round
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < 8; l++) begin
        prod_q[l] <= cnb_q[l] * coef_q[l][ocnt_q];
      end
      p_tag_q <= c_tag;
      for (int l = 0; l < 4; l++) begin
        s4_q[l] <= (PRW+1)'(prod_q[2*l]) + (PRW+1)'(prod_q[2*l+1]);
      end
      a1_tag_q <= p_tag_q;
      for (int l = 0; l < 2; l++) begin
        s2_q[l] <= (PRW+2)'(s4_q[2*l]) + (PRW+2)'(s4_q[2*l+1]);
      end
      a2_tag_q <= a1_tag_q;
      o_q      <= o_d;
    end
  end

  // Drive result channel
  assign vox_out.valid         = o_v_q;
  assign vox_out.out_x         = o_q.out_x;
  assign vox_out.out_y         = o_q.out_y;
  assign vox_out.out_z         = o_q.out_z;
  assign vox_out.out_value     = o_q.out_value;
  assign vox_out.last          = o_q.last;
  assign vox_out.end_of_volume = o_q.end_of_volume;
  assign vox_out.volume_index  = o_q.volume_index;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 2x voxel upscaler. A behavioral copy of the
// transposed convolution predicts the eight result beats of every accepted
// voxel. A checker compares each delivered beat in order against them.
// Stimulus covers coefficient loads and extreme-magnitude volumes, and
// clamped and saturated volume sizes. It then runs random volumes under
// several idle and stall mixes, plus one long output hold-off.
// ----------------------------------------------------------------------------
module tb;

  localparam int CfgPause  = 24;
  localparam int WdogLimit = 5000;
  localparam int HoldLen   = 400;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [vdu_pkg::DimW-1:0] cfg_data_i;

  vdu_in_if  in_ch ();
  vdu_out_if out_ch ();

  voxel_deconv_upscale_2x dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .vox_in     (in_ch),
    .vox_out    (out_ch)
  );

  // Predictor state
  shortint                  coef_table [0:63];
  shortint                  plane_hist [0:1][0:63][0:63];
  logic [vdu_pkg::DimW-1:0] size_reg [0:2];
  int unsigned              col_pos, row_pos, plane_pos, vol_count;
  vdu_pkg::out_beat_t       expected_beats [$];

  int errors = 0;
  int beats_checked = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int voxels_sent, coefs_sent, volumes_done;
  int src_idle, sink_stall;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_dim(logic [vdu_pkg::DimW-1:0] v);
    if (v == '0) begin
      return 1;
    end
    return (v > 64) ? 64 : int'(v);
  endfunction

  // Compute the eight beats of one voxel, then advance the raster position
  function automatic void predict_voxel(shortint vv);
    int unsigned nc, nr, np, i, j, k, widx;
    longint acc;
    bit vol_end;
    vdu_pkg::out_beat_t b;
    nc = eff_dim(size_reg[vdu_pkg::CFG_COLS]);
    nr = eff_dim(size_reg[vdu_pkg::CFG_ROWS]);
    np = eff_dim(size_reg[vdu_pkg::CFG_PLANES]);
    i = col_pos;
    j = row_pos;
    k = plane_pos;
    plane_hist[k & 1][j][i] = vv;
    vol_end = (i + 1 >= nc) && (j + 1 >= nr) && (k + 1 >= np);
    for (int n = 0; n < 8; n++) begin
      acc = 0;
      for (int c = 0; c < 2; c++) begin
        for (int bb = 0; bb < 2; bb++) begin
          for (int a = 0; a < 2; a++) begin
            if (c <= k && bb <= j && a <= i) begin
              widx = ((n & 1) + 2 * a) + 4 * (((n >> 1) & 1) + 2 * bb)
                     + 16 * (((n >> 2) & 1) + 2 * c);
              acc += longint'(plane_hist[(k - c) & 1][j - bb][i - a])
                     * longint'(coef_table[widx]);
            end
          end
        end
      end
      b.out_x         = vdu_pkg::CoordW'(2 * i + (n & 1));
      b.out_y         = vdu_pkg::CoordW'(2 * j + ((n >> 1) & 1));
      b.out_z         = vdu_pkg::CoordW'(2 * k + ((n >> 2) & 1));
      b.out_value     = vdu_pkg::OutW'((acc + 64'sd8192) >>> 14);
      b.last          = (n == 7);
      b.end_of_volume = (n == 7) && vol_end;
      b.volume_index  = vdu_pkg::VolW'(vol_count);
      expected_beats  = {expected_beats, b};
    end
    if (i + 1 < nc) begin
      col_pos = i + 1;
    end else begin
      col_pos = 0;
      if (j + 1 < nr) begin
        row_pos = j + 1;
      end else begin
        row_pos = 0;
        if (k + 1 < np) begin
          plane_pos = k + 1;
        end else begin
          plane_pos = 0;
          vol_count = (vol_count + 1) & 8'hff;
          volumes_done++;
        end
      end
    end
  endfunction

  task automatic report_mismatch(string what, longint want, longint got);
    $display("MISMATCH %s: expected %0d got %0d (beat %0d)", what, want, got,
             beats_checked);
    errors++;
  endtask

  // Offer one beat, idling at random first; valid stays high into the next call
  task automatic send_beat(logic mode, logic [5:0] widx, shortint wv, shortint vv);
    if ($urandom_range(99) < src_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < src_idle) @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= mode;
    in_ch.weight_index <= widx;
    in_ch.weight_value <= wv;
    in_ch.voxel_value  <= vv;
    do @(posedge clk_i); while (!in_ch.ready);
    if (mode == vdu_pkg::MODE_COEF) begin
      coef_table[widx] = wv;
      coefs_sent++;
    end else begin
      predict_voxel(vv);
      voxels_sent++;
    end
  endtask

  task automatic send_voxel(shortint vv);
    send_beat(vdu_pkg::MODE_VOXEL, 6'($urandom), shortint'($urandom), vv);
  endtask

  // Drop valid and wait until the block has drained
  task automatic drain();
    in_ch.valid <= 1'b0;
    wait (expected_beats.size() == 0);
    repeat (CfgPause) @(posedge clk_i);
  endtask

  task automatic write_size(logic [1:0] idx, logic [vdu_pkg::DimW-1:0] val);
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    size_reg[idx] = val;
    col_pos   = 0;
    row_pos   = 0;
    plane_pos = 0;
  endtask

  task automatic set_volume(logic [vdu_pkg::DimW-1:0] c, logic [vdu_pkg::DimW-1:0] r,
                            logic [vdu_pkg::DimW-1:0] p);
    write_size(vdu_pkg::CFG_COLS, c);
    write_size(vdu_pkg::CFG_ROWS, r);
    write_size(vdu_pkg::CFG_PLANES, p);
  endtask

  task automatic load_all_coefs(bit extreme, shortint val);
    for (int w = 0; w < 64; w++) begin
      send_beat(vdu_pkg::MODE_COEF, 6'(w), extreme ? val : shortint'($urandom), 16'sd0);
    end
  endtask

  // Full-scale coefficients and voxels of both signs on 2x2x2 volumes
  task automatic test_extremes();
    src_idle   = 0;
    sink_stall = 0;
    load_all_coefs(1, -16'sd32768);
    set_volume(7'd2, 7'd2, 7'd2);
    repeat (8) send_voxel(-16'sd32768);
    repeat (8) send_voxel(16'sd32767);
    drain();
  endtask

  // Zero acts as one, oversize saturates to the maximum
  task automatic test_sizes();
    set_volume(7'd0, 7'd127, 7'd0);
    repeat (66) send_voxel(shortint'($urandom));
    drain();
  endtask

  // Random volumes with occasional coefficient rewrites in flight
  task automatic test_random(int idle, int stall, int count);
    src_idle   = idle;
    sink_stall = stall;
    set_volume(7'($urandom_range(0, 4)), 7'($urandom_range(0, 4)),
               7'($urandom_range(0, 3)));
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(9) == 0) begin
        send_beat(vdu_pkg::MODE_COEF, 6'($urandom), shortint'($urandom),
                  shortint'($urandom));
      end else begin
        send_voxel(shortint'($urandom));
      end
    end
    drain();
  endtask

  // Long output hold-off while input keeps coming, then a full pause
  task automatic test_backpressure();
    src_idle   = 0;
    sink_stall = 0;
    set_volume(7'd3, 7'd3, 7'd2);
    hold_reqs++;
    repeat (8) send_voxel(shortint'($urandom));
    in_ch.valid <= 1'b0;
    wait (expected_beats.size() == 0);
    repeat (4) send_voxel(shortint'($urandom));
    drain();
  endtask

  // Result checker
  always @(posedge clk_i) begin : check_results
    vdu_pkg::out_beat_t w;
    if (out_ch.valid && out_ch.ready) begin
      if (expected_beats.size() == 0) begin
        report_mismatch("unexpected result beats", 0, 1);
      end else begin
        w = expected_beats.pop_front();
        if (out_ch.out_x != w.out_x) report_mismatch("out_x", w.out_x, out_ch.out_x);
        if (out_ch.out_y != w.out_y) report_mismatch("out_y", w.out_y, out_ch.out_y);
        if (out_ch.out_z != w.out_z) report_mismatch("out_z", w.out_z, out_ch.out_z);
        if (out_ch.out_value != w.out_value)
          report_mismatch("out_value", w.out_value, out_ch.out_value);
        if (out_ch.last != w.last) report_mismatch("last", w.last, out_ch.last);
        if (out_ch.end_of_volume != w.end_of_volume)
          report_mismatch("end_of_volume", w.end_of_volume, out_ch.end_of_volume);
        if (out_ch.volume_index != w.volume_index)
          report_mismatch("volume_index", w.volume_index, out_ch.volume_index);
      end
      beats_checked++;
    end
  end

  // Output ready driver; a requested hold-off is counted here in cycles
  always @(posedge clk_i) begin
    if (hold_reqs != hold_seen) begin
      hold_seen    <= hold_reqs;
      hold_left    <= HoldLen;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= sink_stall);
    end
  end

  // Watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WdogLimit) begin
      $display("timeout: no progress for %0d cycles", WdogLimit);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = vdu_pkg::CFG_COLS;
    cfg_data_i         = '0;
    in_ch.valid        = 1'b0;
    in_ch.mode         = vdu_pkg::MODE_COEF;
    in_ch.weight_index = '0;
    in_ch.weight_value = '0;
    in_ch.voxel_value  = '0;
    voxels_sent = 0; coefs_sent = 0; volumes_done = 0;
    src_idle = 0; sink_stall = 0;
    col_pos = 0; row_pos = 0; plane_pos = 0; vol_count = 0;
    size_reg[0] = 7'd64; size_reg[1] = 7'd64; size_reg[2] = 7'd64;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_extremes();
    test_sizes();
    test_random(0, 0, 15);
    test_random(66, 0, 15);
    test_random(0, 66, 15);
    test_random(26, 26, 15);
    test_backpressure();

    repeat (30) @(posedge clk_i);
    $display("covered %0d voxels and %0d coefficient loads, %0d volumes, %0d beats",
             voxels_sent, coefs_sent, volumes_done, beats_checked);
    $display("full-scale operands, zero and saturated sizes, idle/stall mixes, long hold-off");
    if (errors == 0 && expected_beats.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d beats never arrived", errors, expected_beats.size());
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/vdu_pkg.sv
sv/vdu_if.sv
sv/voxel_deconv_upscale_2x.sv
test/tb.sv
